@@ rtl/core/hciud_pkg.sv @@
// ----------------------------------------------------------------------------
// hciud_pkg: shared types and constants of the H4 deframer with sleep handshake
// Result and command records, codes of the result kinds, errors, receive
// phases and power states, and the H4 and sleep-protocol byte values.
// ----------------------------------------------------------------------------
package hciud_pkg;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_CTRL  = 2'd1;
   localparam logic [1:0] KIND_REL   = 2'd2;
   localparam logic [1:0] KIND_ERR   = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
   localparam logic [2:0] ERR_WAIT_FULL = 3'd3;
   localparam logic [2:0] ERR_SIGNAL    = 3'd4;

   localparam logic [2:0] PH_TYPE = 3'd0;
   localparam logic [2:0] PH_EVT  = 3'd1;
   localparam logic [2:0] PH_ACL  = 3'd2;
   localparam logic [2:0] PH_SCO  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   localparam logic [1:0] PW_ASLEEP   = 2'd0;
   localparam logic [1:0] PW_WAKING   = 2'd1;
   localparam logic [1:0] PW_AWAKE    = 2'd2;
   localparam logic [1:0] PW_SLEEPING = 2'd3;

   localparam logic [7:0] TYPE_ACL  = 8'h02;
   localparam logic [7:0] TYPE_SCO  = 8'h03;
   localparam logic [7:0] TYPE_EVT  = 8'h04;
   localparam logic [7:0] SLEEP_IND = 8'h30;
   localparam logic [7:0] SLEEP_ACK = 8'h31;
   localparam logic [7:0] WAKE_IND  = 8'h32;
   localparam logic [7:0] WAKE_ACK  = 8'h33;

   localparam logic [2:0] HDR_EVT_BYTES = 3'd2;
   localparam logic [2:0] HDR_ACL_BYTES = 3'd4;
   localparam logic [2:0] HDR_SCO_BYTES = 3'd3;

   localparam logic [15:0] MAX_FRAME_RESET = 16'd1028;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;
   localparam int CMDQ_CW    = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ftype;
      logic [7:0] data;
      logic       start;
      logic       fend;
      logic [7:0] pid;
      logic [2:0] err;
   } result_type;

   // One classified input word: up to two fixed results, then an optional
   // push into the wait queue (checked first) or a drain of it (done last).
   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type res0;
      result_type res1;
      logic       push;
      logic       drain;
      logic [7:0] handle;
   } cmd_type;

   function automatic result_type mk_result(input logic [1:0] kind,
                                            input logic [7:0] ftype,
                                            input logic [7:0] data,
                                            input logic       start,
                                            input logic       fend,
                                            input logic [7:0] pid,
                                            input logic [2:0] err);
      result_type r;
      r.kind  = kind;
      r.ftype = ftype;
      r.data  = data;
      r.start = start;
      r.fend  = fend;
      r.pid   = pid;
      r.err   = err;
      return r;
   endfunction

endpackage

@@ rtl/core/hci_uart_deframer_with_sleep_handshake_core.sv @@
// ----------------------------------------------------------------------------
// hci_uart_deframer_with_sleep_handshake_core: H4 deframer with sleep handshake
// Splits received UART bytes into H4 event, ACL and SCO frames and runs the
// sleep/wake handshake, holding host packets while the device sleeps.
// ----------------------------------------------------------------------------
// A request word is taken whenever the four-entry command queue has room;
// the front end classifies it and updates the receive and power state at
// once. Only the three frame type bytes leave nothing for the back end; every
// other word becomes one queued command. The back end takes a command and
// then issues its result words one at a time as the result channel takes
// them; a host packet queued while waking gives no result word unless the
// wait queue is full. On wake the wait queue is drained one released packet
// at a time, because each entry is read from the wait memory through a
// registered port before its release word is loaded. Stalls on the result
// channel hold the back end. max_frame_bytes is written through csr_we and
// csr_wdata and should only change while the block is idle.
module hci_uart_deframer_with_sleep_handshake_core #(
   parameter int WAIT_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,      // max_frame_bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,      // rx_byte [7:0], tx_handle [15:8]
   input  logic        req_tuser,      // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_type [7:0], data_byte [15:8], frame_start [16], frame_end [17],
   // packet_id [25:18], error_code [28:26], zero [31:29]
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,      // result_kind
   output logic        rsp_tlast       // last result of the request word
);
   import hciud_pkg::*;

   logic       fq_valid, fq_ready, qb_valid, qb_ready;
   cmd_type    fq_cmd, qb_cmd;
   result_type out_res;

   hciud_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_op        (req_tuser),
      .in_rx_byte   (req_tdata[7:0]),
      .in_tx_handle (req_tdata[15:8]),
      .cmd_valid    (fq_valid),
      .cmd          (fq_cmd),
      .cmd_ready    (fq_ready)
   );

   hciud_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_cmd   (fq_cmd),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_cmd   (qb_cmd)
   );

   hciud_back #(
      .WAIT_DEPTH (WAIT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd       (qb_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = out_res.kind;
   assign rsp_tdata = {3'b000, out_res.err, out_res.pid, out_res.fend, out_res.start,
                       out_res.data, out_res.ftype};

endmodule

@@ rtl/core/hciud_front.sv @@
// ----------------------------------------------------------------------------
// hciud_front: deframer and power-state front end
// Classifies each input word, tracks the H4 receive phase and the power
// state, and turns the word into a command for the back end.
// ----------------------------------------------------------------------------
module hciud_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_op,
   input  logic [7:0]            in_rx_byte,
   input  logic [7:0]            in_tx_handle,
   output logic                  cmd_valid,
   output hciud_pkg::cmd_type    cmd,
   input  logic                  cmd_ready
);
   import hciud_pkg::*;

   logic [15:0] max_frame_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [7:0]  hdr2_ff, hdr2_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [1:0]  power_ff, power_in;

   logic        accept;
   logic [2:0]  hdr_next;
   logic [2:0]  hdr_size;
   logic [15:0] size16;
   logic [15:0] frame_len;
   logic [15:0] room;
   logic        hdr_start;
   logic        has_work;

   assign in_ready = cmd_ready;
   assign accept   = in_valid && in_ready;
   assign has_work = cmd.v0 || cmd.v1 || cmd.push || cmd.drain;
   assign cmd_valid = in_valid && has_work;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      cur_type_in   = cur_type_ff;
      hdr2_in       = hdr2_ff;
      hdr_idx_in    = hdr_idx_ff;
      power_in      = power_ff;
      cmd           = '0;
      cmd.handle    = in_tx_handle;

      hdr_next  = hdr_idx_ff + 3'd1;
      hdr_start = (hdr_idx_ff == 3'd0);
      if (phase_ff == PH_EVT) begin
         hdr_size = HDR_EVT_BYTES;
      end else if (phase_ff == PH_ACL) begin
         hdr_size = HDR_ACL_BYTES;
      end else begin
         hdr_size = HDR_SCO_BYTES;
      end
      // The length byte of event and SCO headers is the last header byte;
      // ACL carries it little-endian in the last two.
      frame_len = (phase_ff == PH_ACL) ? {in_rx_byte, hdr2_ff} : {8'h00, in_rx_byte};
      size16    = {13'd0, hdr_size};
      room      = (max_frame_ff > size16) ? (max_frame_ff - size16) : 16'd0;

      if (!in_op) begin
         priority if (phase_ff == PH_EVT || phase_ff == PH_ACL || phase_ff == PH_SCO) begin
            if (hdr_idx_ff == 3'd2) begin
               hdr2_in = in_rx_byte;
            end
            hdr_idx_in = hdr_next;
            cmd.v0 = 1'b1;
            cmd.res0 = mk_result(KIND_FRAME, cur_type_ff, in_rx_byte, hdr_start, 1'b0,
                                 8'h00, ERR_NONE);
            if (hdr_next >= hdr_size) begin
               hdr_idx_in = 3'd0;
               if (frame_len == 16'd0) begin
                  cmd.res0.fend = 1'b1;
                  phase_in      = PH_TYPE;
                  bytes_left_in = 16'd0;
               end else if (frame_len > room) begin
                  cmd.v1 = 1'b1;
                  cmd.res1 = mk_result(KIND_ERR, cur_type_ff, 8'h00, 1'b0, 1'b1,
                                       8'h00, ERR_TOO_LONG);
                  phase_in      = PH_TYPE;
                  bytes_left_in = 16'd0;
               end else begin
                  phase_in      = PH_DATA;
                  bytes_left_in = frame_len;
               end
            end
         end else if (phase_ff == PH_DATA && bytes_left_ff != 16'd0) begin
            bytes_left_in = bytes_left_ff - 16'd1;
            cmd.v0 = 1'b1;
            cmd.res0 = mk_result(KIND_FRAME, cur_type_ff, in_rx_byte, 1'b0,
                                 bytes_left_ff == 16'd1, 8'h00, ERR_NONE);
            if (bytes_left_ff == 16'd1) begin
               phase_in = PH_TYPE;
            end
         end else begin
            phase_in      = PH_TYPE;
            bytes_left_in = 16'd0;
            unique case (in_rx_byte)
               TYPE_EVT, TYPE_ACL, TYPE_SCO: begin
                  if (in_rx_byte == TYPE_EVT) begin
                     phase_in = PH_EVT;
                  end else if (in_rx_byte == TYPE_ACL) begin
                     phase_in = PH_ACL;
                  end else begin
                     phase_in = PH_SCO;
                  end
                  cur_type_in = in_rx_byte;
                  hdr_idx_in  = 3'd0;
               end
               SLEEP_IND: begin
                  cmd.v0 = (power_ff != PW_AWAKE);
                  cmd.res0 = mk_result(KIND_ERR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00,
                                       ERR_SIGNAL);
                  cmd.v1 = 1'b1;
                  cmd.res1 = mk_result(KIND_CTRL, 8'h00, SLEEP_ACK, 1'b0, 1'b0, 8'h00,
                                       ERR_NONE);
                  power_in = PW_ASLEEP;
               end
               SLEEP_ACK: begin
                  cmd.v0 = 1'b1;
                  cmd.res0 = mk_result(KIND_ERR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00,
                                       ERR_SIGNAL);
               end
               WAKE_IND: begin
                  cmd.v0 = 1'b1;
                  if (power_ff == PW_ASLEEP || power_ff == PW_WAKING) begin
                     cmd.res0 = mk_result(KIND_CTRL, 8'h00, WAKE_ACK, 1'b0, 1'b0, 8'h00,
                                          ERR_NONE);
                  end else begin
                     cmd.res0 = mk_result(KIND_ERR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00,
                                          ERR_SIGNAL);
                  end
                  cmd.drain = 1'b1;
                  power_in  = PW_AWAKE;
               end
               WAKE_ACK: begin
                  cmd.v0 = (power_ff != PW_WAKING);
                  cmd.res0 = mk_result(KIND_ERR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00,
                                       ERR_SIGNAL);
                  cmd.drain = 1'b1;
                  power_in  = PW_AWAKE;
               end
               default: begin
                  cmd.v0 = 1'b1;
                  cmd.res0 = mk_result(KIND_ERR, 8'h00, in_rx_byte, 1'b0, 1'b0, 8'h00,
                                       ERR_UNKNOWN);
               end
            endcase
         end
      end else begin
         unique case (power_ff)
            PW_AWAKE: begin
               cmd.v0 = 1'b1;
               cmd.res0 = mk_result(KIND_REL, 8'h00, 8'h00, 1'b0, 1'b0, in_tx_handle,
                                    ERR_NONE);
            end
            PW_ASLEEP: begin
               cmd.push = 1'b1;
               cmd.v0   = 1'b1;
               cmd.res0 = mk_result(KIND_CTRL, 8'h00, WAKE_IND, 1'b0, 1'b0, 8'h00,
                                    ERR_NONE);
               power_in = PW_WAKING;
            end
            PW_WAKING: begin
               cmd.push = 1'b1;
            end
            default: begin
               cmd.v0 = 1'b1;
               cmd.res0 = mk_result(KIND_ERR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00,
                                    ERR_SIGNAL);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff  <= MAX_FRAME_RESET;
         phase_ff      <= PH_TYPE;
         bytes_left_ff <= 16'd0;
         cur_type_ff   <= 8'h00;
         hdr_idx_ff    <= 3'd0;
         power_ff      <= PW_AWAKE;
      end else begin
         if (csr_we) begin
            max_frame_ff <= csr_wdata;
         end
         if (accept) begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            cur_type_ff   <= cur_type_in;
            hdr_idx_ff    <= hdr_idx_in;
            power_ff      <= power_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr2_ff <= hdr2_in;
      end
   end

endmodule

@@ rtl/core/hciud_cmdq.sv @@
// ----------------------------------------------------------------------------
// hciud_cmdq: command queue between front and back end
// A small FIFO of classified commands so that either side can stall alone.
// ----------------------------------------------------------------------------
module hciud_cmdq (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  hciud_pkg::cmd_type  wr_cmd,
   output logic                rd_valid,
   input  logic                rd_ready,
   output hciud_pkg::cmd_type  rd_cmd
);
   import hciud_pkg::*;

   cmd_type             slots [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CMDQ_CW-1:0]  count_ff;
   logic                do_wr, do_rd;

   assign wr_ready = (count_ff != CMDQ_CW'(CMDQ_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;
   assign rd_cmd   = slots[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + CMDQ_AW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + CMDQ_AW'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CMDQ_CW'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CMDQ_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ rtl/core/hciud_back.sv @@
// ----------------------------------------------------------------------------
// hciud_back: result sequencer and host wait queue
// Expands each command into result words, owns the FIFO of host packets held
// while the device sleeps, and drives the registered result channel.
// ----------------------------------------------------------------------------
module hciud_back #(
   parameter int WAIT_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  hciud_pkg::cmd_type     cmd,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hciud_pkg::result_type  out_res,
   output logic                   out_last
);
   import hciud_pkg::*;

   localparam int WAIT_AW = $clog2(WAIT_DEPTH);
   localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
   localparam int SUM_W   = WAIT_AW + 1;

   logic [7:0]          wait_mem [WAIT_DEPTH];
   logic [7:0]          rd_data_ff;
   logic [WAIT_AW-1:0]  head_ff, head_in, head_inc, wr_addr;
   logic [WAIT_CW-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]    wr_sum;
   logic                pe3_ff, pe3_in;
   logic                v0_ff, v0_in, v1_ff, v1_in;
   logic                drain_ff, drain_in;
   logic                rd_wait_ff, rd_wait_in;
   result_type          res0_ff, res0_in, res1_ff, res1_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_res_ff;
   logic                rsp_last_ff;
   logic                busy, out_free, more_rel;
   logic                mem_we, mem_re, load, load_last;
   result_type          load_res;

   assign busy      = pe3_ff || v0_ff || v1_ff || drain_ff;
   assign cmd_ready = !busy;
   assign out_free  = !rsp_valid_ff || out_ready;
   assign more_rel  = drain_ff && (count_ff != '0);
   assign head_inc  = (head_ff == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : head_ff + WAIT_AW'(1);
   assign wr_sum    = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_addr   = (wr_sum >= SUM_W'(WAIT_DEPTH)) ? WAIT_AW'(wr_sum - SUM_W'(WAIT_DEPTH))
                                                     : WAIT_AW'(wr_sum);

   always_comb begin
      pe3_in     = pe3_ff;
      v0_in      = v0_ff;
      v1_in      = v1_ff;
      drain_in   = drain_ff;
      rd_wait_in = rd_wait_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      res0_in    = res0_ff;
      res1_in    = res1_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      load       = 1'b0;
      load_last  = 1'b0;
      load_res   = '0;

      priority if (!busy) begin
         if (cmd_valid) begin
            v0_in    = cmd.v0;
            v1_in    = cmd.v1;
            res0_in  = cmd.res0;
            res1_in  = cmd.res1;
            drain_in = cmd.drain;
            if (cmd.push) begin
               if (count_ff == WAIT_CW'(WAIT_DEPTH)) begin
                  pe3_in = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + WAIT_CW'(1);
               end
            end
         end
      end else if (pe3_ff) begin
         if (out_free) begin
            load      = 1'b1;
            load_res  = mk_result(KIND_ERR, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, ERR_WAIT_FULL);
            load_last = !(v0_ff || v1_ff);
            pe3_in    = 1'b0;
         end
      end else if (v0_ff) begin
         if (out_free) begin
            load      = 1'b1;
            load_res  = res0_ff;
            load_last = !v1_ff && !more_rel;
            v0_in     = 1'b0;
         end
      end else if (v1_ff) begin
         if (out_free) begin
            load      = 1'b1;
            load_res  = res1_ff;
            load_last = !more_rel;
            v1_in     = 1'b0;
         end
      end else begin
         // Drain: each release first reads the head entry into rd_data_ff.
         if (count_ff == '0) begin
            drain_in = 1'b0;
            head_in  = '0;
         end else if (!rd_wait_ff) begin
            mem_re     = 1'b1;
            rd_wait_in = 1'b1;
         end else if (out_free) begin
            load       = 1'b1;
            load_res   = mk_result(KIND_REL, 8'h00, 8'h00, 1'b0, 1'b0, rd_data_ff, ERR_NONE);
            load_last  = (count_ff == WAIT_CW'(1));
            count_in   = count_ff - WAIT_CW'(1);
            rd_wait_in = 1'b0;
            if (count_ff == WAIT_CW'(1)) begin
               head_in  = '0;
               drain_in = 1'b0;
            end else begin
               head_in = head_inc;
            end
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pe3_ff       <= 1'b0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         drain_ff     <= 1'b0;
         rd_wait_ff   <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pe3_ff       <= pe3_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         drain_ff     <= drain_in;
         rd_wait_ff   <= rd_wait_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res0_ff <= res0_in;
      res1_ff <= res1_in;
      if (load) begin
         rsp_res_ff  <= load_res;
         rsp_last_ff <= load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wait_mem[wr_addr] <= cmd.handle;
      end
      if (mem_re) begin
         rd_data_ff <= wait_mem[head_ff];
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_res   = rsp_res_ff;
   assign out_last  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= WAIT_CW'(WAIT_DEPTH))
      else $error("wait queue count above its depth");

   a_full_error: assert property (@(posedge clock) disable iff (reset)
      pe3_ff |-> (count_ff == WAIT_CW'(WAIT_DEPTH)))
      else $error("queue-full error pending while the wait queue has room");

   a_read_in_drain: assert property (@(posedge clock) disable iff (reset)
      rd_wait_ff |-> (drain_ff && !pe3_ff && !v0_ff && !v1_ff))
      else $error("wait queue read outstanding outside a drain");

   a_head_rewind: assert property (@(posedge clock) disable iff (reset)
      $fell(drain_ff) |-> (head_ff == '0 && count_ff == '0))
      else $error("drain ended with the wait queue not empty or not rewound");

endmodule
